### rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared constants for the stack machine executor: sizes, command codes and
// result status codes.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [DEPTH_W-1:0]     depth_t;
    typedef logic [2:0]             cmd_t;
    typedef logic [1:0]             status_t;

    localparam cmd_t CMD_PUSH = 3'd0;
    localparam cmd_t CMD_ADD  = 3'd1;
    localparam cmd_t CMD_SUB  = 3'd2;
    localparam cmd_t CMD_MUL  = 3'd3;
    localparam cmd_t CMD_DIV  = 3'd4;
    localparam cmd_t CMD_NEG  = 3'd5;
    localparam cmd_t CMD_RET  = 3'd6;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_RET   = 2'd1;
    localparam status_t STATUS_STACK = 2'd2;
    localparam status_t STATUS_DIV0  = 2'd3;

endpackage

### rtl/sme_ram.sv
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sme_div.sv
// ----------------------------------------------------------------------------
// sme_div
// Iterative signed divider: one quotient bit per cycle, restoring scheme on
// magnitudes, quotient truncated toward zero and wrapped to the value width.
// ----------------------------------------------------------------------------
module sme_div
    import sme_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  value_t dividend,
    input  value_t divisor,
    output logic   done,
    output value_t quotient
);

    value_t            rem_reg, rem_next;
    value_t            quo_reg, quo_next;
    value_t            dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            // load magnitudes and remember the quotient sign
            rem_next = '0;
            quo_next = dividend[VALUE_WIDTH-1] ? value_t'(-dividend) : dividend;
            dvs_next = divisor[VALUE_WIDTH-1] ? value_t'(-divisor) : divisor;
            neg_next = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
            cnt_next = CNT_W'(VALUE_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[VALUE_WIDTH])
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? value_t'(-quo_reg) : quo_reg;

endmodule

### rtl/stack_machine_arith_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_arith_executor
// Executes one decoded stack instruction per item. The top of stack lives in
// a register, the entries below it in a synchronous RAM.
//
//   channel   direction  handshake             fields
//   command   in         start / busy          command, constant_value
//   result    out        done (one-cycle)      status, top_value, stack_depth
//
// Push, negate, return, unused codes and all error cases finish in S_IDLE:
// the result appears the cycle after start and busy never rises.
// Add and subtract go through S_EXEC (RAM read of the second operand),
// multiply also through S_MUL (registered product), divide through S_DIV
// while the one-bit-per-cycle divider runs. Reset empties the stack at once;
// the RAM needs no clearing since only written entries are read. The receiver
// cannot stall; start is taken whenever busy is low.
// ----------------------------------------------------------------------------
module stack_machine_arith_executor
    import sme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] constant_value,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] top_value,
    output logic [8:0]  stack_depth
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0] state_reg, state_next;
    depth_t     depth_reg, depth_next;
    value_t     top_reg, top_next;
    cmd_t       cmd_reg, cmd_next;
    value_t     prod_reg, prod_next;

    logic       done_reg, done_next;
    status_t    status_reg, status_next;
    value_t     out_top_reg, out_top_next;
    depth_t     out_depth_reg, out_depth_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    value_t            ram_rdata;

    logic   div_start;
    logic   div_done;
    value_t div_quot;

    logic   accept;
    value_t cur_top;
    value_t sum;
    value_t diff;

    assign accept  = start && (state_reg == S_IDLE);
    assign cur_top = (depth_reg == '0) ? '0 : top_reg;
    assign sum     = ram_rdata + top_reg;
    assign diff    = ram_rdata - top_reg;

    // stack entries below the top
    assign ram_waddr = depth_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign ram_raddr = depth_reg[ADDR_W-1:0] - ADDR_W'(2);

    sme_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // instruction sequencer
    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        top_next       = top_reg;
        cmd_next       = cmd_reg;
        prod_next      = prod_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_top_next   = out_top_reg;
        out_depth_next = out_depth_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next      = 1'b1;
                    status_next    = STATUS_OK;
                    out_top_next   = cur_top;
                    out_depth_next = depth_reg;
                    cmd_next       = command;
                    unique case (command) inside
                        CMD_PUSH:
                        begin
                            if (depth_reg >= DEPTH_W'(STACK_DEPTH))
                            begin
                                status_next = STATUS_STACK;
                            end
                            else
                            begin
                                // spill the old top below the new one
                                ram_we         = (depth_reg != '0);
                                top_next       = constant_value;
                                depth_next     = depth_reg + DEPTH_W'(1);
                                out_top_next   = constant_value;
                                out_depth_next = depth_reg + DEPTH_W'(1);
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        begin
                            if (depth_reg < DEPTH_W'(2))
                            begin
                                status_next = STATUS_STACK;
                            end
                            else if (command == CMD_DIV && top_reg == '0)
                            begin
                                status_next = STATUS_DIV0;
                            end
                            else
                            begin
                                // wait for the second operand from the RAM
                                done_next  = 1'b0;
                                state_next = S_EXEC;
                            end
                        end
                        CMD_NEG:
                        begin
                            if (depth_reg == '0)
                            begin
                                status_next = STATUS_STACK;
                            end
                            else
                            begin
                                top_next     = value_t'(-top_reg);
                                out_top_next = value_t'(-top_reg);
                            end
                        end
                        CMD_RET:
                        begin
                            if (depth_reg == '0)
                            begin
                                status_next = STATUS_STACK;
                            end
                            else
                            begin
                                status_next    = STATUS_RET;
                                out_top_next   = top_reg;
                                depth_next     = '0;
                                out_depth_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg) inside
                    CMD_ADD, CMD_SUB:
                    begin
                        top_next       = (cmd_reg == CMD_ADD) ? sum : diff;
                        depth_next     = depth_reg - DEPTH_W'(1);
                        done_next      = 1'b1;
                        status_next    = STATUS_OK;
                        out_top_next   = (cmd_reg == CMD_ADD) ? sum : diff;
                        out_depth_next = depth_reg - DEPTH_W'(1);
                        state_next     = S_IDLE;
                    end
                    CMD_MUL:
                    begin
                        prod_next  = value_t'(ram_rdata * top_reg);
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                endcase
            end
            S_MUL:
            begin
                top_next       = prod_reg;
                depth_next     = depth_reg - DEPTH_W'(1);
                done_next      = 1'b1;
                status_next    = STATUS_OK;
                out_top_next   = prod_reg;
                out_depth_next = depth_reg - DEPTH_W'(1);
                state_next     = S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    top_next       = div_quot;
                    depth_next     = depth_reg - DEPTH_W'(1);
                    done_next      = 1'b1;
                    status_next    = STATUS_OK;
                    out_top_next   = div_quot;
                    out_depth_next = depth_reg - DEPTH_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        cmd_reg       <= cmd_next;
        prod_reg      <= prod_next;
        status_reg    <= status_next;
        out_top_reg   <= out_top_next;
        out_depth_reg <= out_depth_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign top_value   = out_top_reg;
    assign stack_depth = out_depth_reg;

endmodule
